// File: hdl/mpqh_pkg.sv
// Shared types, codes and the priority compare for the max-heap priority queue.
`default_nettype none
package mpqh_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0]        ticket;
    logic signed [31:0] amount;
  } entry_t;

  // true when a sits strictly above b: larger amount, then smaller ticket
  function automatic logic outranks(entry_t a, entry_t b);
    logic res;
    if (a.amount != b.amount) begin
      res = (a.amount > b.amount);
    end else begin
      res = (a.ticket < b.ticket);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/max_priority_queue_heap_unit.sv
// Binary max-heap priority queue built around one single-port-read entry memory.
//
// Input channel (in_valid_i / in_stall_o): one request is an insert (action 0,
// ticket_i, amount_i) or a remove (action 1). Output channel (out_valid_o /
// out_stall_i) returns one result per request: removed ticket, status and the
// occupancy after the request.
// Requests are handled one at a time; in_stall_o is high from acceptance until
// the result has been taken. Latency is set by the heap walk through the memory,
// whose read data arrives in the cycle after the address. An insert moves the
// new entry up from the first free slot while it outranks its parent; a remove
// takes the root, moves the last entry to the root and sifts it down unless that
// was the last entry; a full insert or an empty remove goes straight to the
// result.
// The result holds on the output until it is taken, and the unit then returns to
// idle before it takes the next request.
// Reset clears the entry count and the handshake state; the memory is not
// cleared, since only entries below the count are ever read.
// While the receiver stalls, the result holds and no new request is taken.
`default_nettype none
module max_priority_queue_heap_unit
  import mpqh_pkg::*;
#(
  parameter int CAPACITY = 1024,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               action_i,
  input  wire  [31:0]       ticket_i,
  input  wire signed [31:0] amount_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [31:0]       removed_ticket_o,
  output logic [1:0]        status_o,
  output logic [CW-1:0]     occupancy_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_RM_ROOT = 4'd3;
  localparam logic [3:0] S_RM_LAST = 4'd4;
  localparam logic [3:0] S_DN_L    = 4'd5;
  localparam logic [3:0] S_DN_R    = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  entry_t        cur_q, cur_d;
  entry_t        left_q, left_d;
  logic [31:0]   taken_q, taken_d;
  logic [1:0]    stat_q, stat_d;

  // entry memory
  entry_t        mem [CAPACITY];
  entry_t        rdata_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  logic [AW+1:0] lidx, ridx;
  logic [AW-1:0] parent;
  logic          l_ok, r_ok;
  logic          pick_l, pick_r;
  entry_t        best_lc;

  always_comb begin
    lidx   = {1'b0, pos_q, 1'b1};
    ridx   = {1'b0, pos_q, 1'b0} + (AW+2)'(2);
    parent = (pos_q - AW'(1)) >> 1;
    l_ok   = lidx < (AW+2)'(cnt_q);
    r_ok   = ridx < (AW+2)'(cnt_q);
    pick_l = outranks(left_q, cur_q);
    best_lc = pick_l ? left_q : cur_q;
    pick_r = r_ok && outranks(rdata_q, best_lc);
  end

  logic finish;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    left_d  = left_q;
    taken_d = taken_q;
    stat_d  = stat_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wdata   = cur_q;
    finish  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          taken_d = '0;
          stat_d  = STATUS_DONE;
          if (action_i == ACT_INSERT) begin
            if (cnt_q == CAP_CNT) begin
              stat_d  = STATUS_FULL;
              state_d = S_OUT;
            end else begin
              cur_d   = '{ticket: ticket_i, amount: amount_i};
              pos_d   = cnt_q[AW-1:0];
              cnt_d   = cnt_q + CW'(1);
              state_d = S_UP_RD;
            end
          end else if (cnt_q == '0) begin
            stat_d  = STATUS_EMPTY;
            state_d = S_OUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            cnt_d   = cnt_q - CW'(1);
            state_d = S_RM_ROOT;
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (outranks(cur_q, rdata_q)) begin
          // parent moves down into the hole
          wdata   = rdata_q;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          finish = 1'b1;
        end
      end
      S_RM_ROOT: begin
        taken_d = rdata_q.ticket;
        rd_en   = 1'b1;
        rd_addr = cnt_q[AW-1:0];
        state_d = S_RM_LAST;
      end
      S_RM_LAST: begin
        cur_d = rdata_q;
        pos_d = '0;
        if (cnt_q == '0) begin
          finish = 1'b1;
        end else begin
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        if (!l_ok) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lidx[AW-1:0];
          state_d = S_DN_R;
        end
      end
      S_DN_R: begin
        left_d = rdata_q;
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = ridx[AW-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (pick_r) begin
          wdata   = rdata_q;
          pos_d   = ridx[AW-1:0];
          state_d = S_DN_L;
        end else if (pick_l) begin
          wdata   = left_q;
          pos_d   = lidx[AW-1:0];
          state_d = S_DN_L;
        end else begin
          finish = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (finish) begin
      state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cur_q   <= cur_d;
    left_q  <= left_d;
    taken_q <= taken_d;
    stat_q  <= stat_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign removed_ticket_o = taken_q;
  assign status_o         = stat_q;
  assign occupancy_o      = cnt_q;

endmodule
`default_nettype wire

// File: tb/tb_max_priority_queue_heap_unit.sv
// Self-checking testbench for the max-heap priority queue unit.
`default_nettype none
module tb_max_priority_queue_heap_unit;
  import mpqh_pkg::*;

  localparam int CAP = 1024;
  localparam int CW = $clog2(CAP + 1);

  typedef struct packed {
    logic [31:0]   ticket;
    logic [1:0]    status;
    logic [CW-1:0] occupancy;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic action_i = ACT_INSERT;
  logic [31:0] ticket_i = '0;
  logic signed [31:0] amount_i = '0;
  logic out_stall_i = 1'b0;
  wire in_stall_o;
  wire out_valid_o;
  wire [31:0] removed_ticket_o;
  wire [1:0] status_o;
  wire [CW-1:0] occupancy_o;

  max_priority_queue_heap_unit #(.CAPACITY(CAP)) DUT (.*);

  // predictor state
  entry_t   heap_q[CAP];
  int       held;
  outcome_t expected_q[$];
  int       errors = 0;
  int       burst_left = 0;
  bit       stall_busy = 1'b0;

  initial forever #4 clk_i = ~clk_i;

  function automatic bit higher(entry_t a, entry_t b);
    if (a.amount != b.amount) return a.amount > b.amount;
    return a.ticket < b.ticket;
  endfunction

  function automatic outcome_t predict_queue(logic act, logic [31:0] tk, logic [31:0] am);
    outcome_t o;
    entry_t t;
    int p, up, l, r, best;
    o = '0;
    if (act == ACT_INSERT) begin
      if (held >= CAP) o.status = STATUS_FULL;
      else begin
        heap_q[held] = '{ticket: tk, amount: am};
        p = held;
        held++;
        while (p > 0) begin
          up = (p - 1) / 2;
          if (!higher(heap_q[p], heap_q[up])) break;
          t = heap_q[p]; heap_q[p] = heap_q[up]; heap_q[up] = t;
          p = up;
        end
      end
    end else begin
      if (held == 0) o.status = STATUS_EMPTY;
      else begin
        o.ticket = heap_q[0].ticket;
        held--;
        heap_q[0] = heap_q[held];
        p = 0;
        forever begin
          l = 2 * p + 1; r = 2 * p + 2; best = p;
          if (l < held && higher(heap_q[l], heap_q[best])) best = l;
          if (r < held && higher(heap_q[r], heap_q[best])) best = r;
          if (best == p) break;
          t = heap_q[p]; heap_q[p] = heap_q[best]; heap_q[best] = t;
          p = best;
        end
      end
    end
    o.occupancy = held[CW-1:0];
    return o;
  endfunction

  // sender: bursts with random gaps; one request per call
  // valid drops only in a gap; the unit stalls after each acceptance anyway
  task automatic send_request(logic act, logic [31:0] tk, logic [31:0] am);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i <= act;
    ticket_i <= tk;
    amount_i <= am;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_queue(act, tk, am));
  endtask

  // receiver stall pattern: alternating calm and stormy stretches
  always @(posedge clk_i) begin
    if (!stall_busy) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 199) == 0) stall_busy <= ~stall_busy;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: ticket %0d", removed_ticket_o);
        errors++;
      end else begin
        outcome_t e;
        e = expected_q.pop_front();
        if (removed_ticket_o !== e.ticket) begin
          $error("removed_ticket exp %0d got %0d", e.ticket, removed_ticket_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (occupancy_o !== e.occupancy) begin
          $error("occupancy exp %0d got %0d", e.occupancy, occupancy_o); errors++;
        end
      end
    end
  end

  task automatic test_directed_edges();
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF); // empty remove
    send_request(ACT_INSERT, 32'h0, 32'h8000_0000);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(ACT_INSERT, 32'h5, 32'h7FFF_FFFF);          // tie, smaller ticket wins
    send_request(ACT_INSERT, 32'h5, 32'h7FFF_FFFF);          // identical entry
    send_request(ACT_INSERT, 32'h8000_0000, 32'h0);
    send_request(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    repeat (7) send_request(ACT_REMOVE, $urandom, $urandom);
  endtask

  task automatic test_fill_to_full();
    // fill with small value range so ties are common, overflow, then drain part
    while (held < CAP)
      send_request(ACT_INSERT, $urandom_range(0, 15), $urandom_range(0, 7) - 4);
    send_request(ACT_INSERT, $urandom, $urandom);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    repeat (100) send_request(ACT_REMOVE, $urandom, $urandom);
  endtask

  task automatic test_random_mix();
    logic [31:0] tk, am;
    int rm_pct;
    for (int n = 0; n < 200; n++) begin
      tk = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 7);
      am = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 6) - 3;
      rm_pct = ((n / 50) % 2) ? 60 : 20;
      send_request(($urandom_range(0, 99) < rm_pct) ? ACT_REMOVE : ACT_INSERT, tk, am);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    held = 0;
    test_directed_edges();
    test_random_mix();
    test_fill_to_full();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/mpqh_pkg.sv
hdl/max_priority_queue_heap_unit.sv
tb/tb_max_priority_queue_heap_unit.sv
